// ----- hw/rtl/mbp_pkg.sv -----
// shared constants, parse modes and controller/datapath interface structs
// for the midi byte stream parser; no dependencies
`default_nettype none

package mbp_pkg;

   localparam int PARSE_DEPTH_DEF = 64;

   // parse modes
   localparam logic [2:0] MODE_READY = 3'd0;
   localparam logic [2:0] MODE_TWO   = 3'd1;
   localparam logic [2:0] MODE_THREE = 3'd2;
   localparam logic [2:0] MODE_EXCL  = 3'd3;
   localparam logic [2:0] MODE_TC    = 3'd4;
   localparam logic [2:0] MODE_SYS1  = 3'd5;
   localparam logic [2:0] MODE_SYS2  = 3'd6;
   localparam logic [2:0] MODE_SYS3  = 3'd7;

   // result kinds
   localparam logic [1:0] KIND_TWO   = 2'd0;
   localparam logic [1:0] KIND_THREE = 2'd1;
   localparam logic [1:0] KIND_SYSEX = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   // byte codes
   localparam logic [7:0] BYTE_RS_INIT = 8'h80;
   localparam logic [7:0] BYTE_SYSEX   = 8'hF0;
   localparam logic [7:0] BYTE_TC      = 8'hF1;
   localparam logic [7:0] BYTE_SPP     = 8'hF2;
   localparam logic [7:0] BYTE_SSEL    = 8'hF3;
   localparam logic [7:0] BYTE_TUNE    = 8'hF6;
   localparam logic [7:0] BYTE_EOX     = 8'hF7;
   localparam logic [7:0] BYTE_MMC_NRT = 8'h7E;
   localparam logic [7:0] BYTE_MMC_RT  = 8'h7F;
   localparam logic [3:0] NIB_PROG     = 4'hC;
   localparam logic [3:0] NIB_PRESS    = 4'hD;
   localparam logic [3:0] NIB_SYS      = 4'hF;

   typedef struct packed {
      logic       is_data;
      logic       is_mmc;
      logic       is_eox;
      logic       is_start;
      logic [2:0] new_mode;
      logic       cnt_two;
      logic       cnt_last;
      logic       rd_last;
      logic       out_free;
   } dp_sts_type;

   typedef struct packed {
      logic start_msg;
      logic set_rs;
      logic run_status;
      logic append;
      logic clear;
      logic emit_two;
      logic emit_three;
      logic rd_start;
      logic emit_sysex;
   } dp_cmd_type;

endpackage

`default_nettype wire

// ----- hw/rtl/mbp_datapath.sv -----
// datapath: byte decode, running status, message bytes, sysex store and
// the result register; uses mbp_pkg
`default_nettype none

module mbp_datapath #(
   parameter int PARSE_DEPTH = mbp_pkg::PARSE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         req_byte,
   input  wire mbp_pkg::dp_cmd_type cmd,
   output mbp_pkg::dp_sts_type     sts,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_kind,
   output logic [7:0]              rsp_status,
   output logic [7:0]              rsp_data_one,
   output logic [7:0]              rsp_data_two,
   output logic                    rsp_last
);
   import mbp_pkg::*;

   localparam int CNT_W  = $clog2(PARSE_DEPTH + 1);
   localparam int ADDR_W = $clog2(PARSE_DEPTH);

   logic [7:0]        rs_ff, rs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              valid_ff, valid_in;
   logic [7:0]        b0_ff, b1_ff;
   logic [CNT_W-1:0]  rd_idx_ff;
   logic [7:0]        mem_q_ff;
   logic [1:0]        kind_ff;
   logic [7:0]        stat_ff, d1_ff, d2_ff;
   logic              last_ff;
   logic [7:0]        mem [PARSE_DEPTH];
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [3:0]        hi;

   // byte decode and counter flags
   always_comb begin
      hi           = req_byte[7:4];
      sts          = '0;
      sts.is_data  = !req_byte[7];
      sts.is_mmc   = (req_byte == BYTE_MMC_NRT) || (req_byte == BYTE_MMC_RT);
      sts.is_eox   = (req_byte == BYTE_EOX);
      sts.new_mode = MODE_READY;
      if (req_byte[7]) begin
         if (hi == NIB_PROG || hi == NIB_PRESS) begin
            sts.is_start = 1'b1;
            sts.new_mode = MODE_TWO;
         end else if (hi != NIB_SYS) begin
            sts.is_start = 1'b1;
            sts.new_mode = MODE_THREE;
         end else begin
            unique case (req_byte)
               BYTE_SYSEX: begin sts.is_start = 1'b1; sts.new_mode = MODE_EXCL; end
               BYTE_TC:    begin sts.is_start = 1'b1; sts.new_mode = MODE_TC;   end
               BYTE_SPP:   begin sts.is_start = 1'b1; sts.new_mode = MODE_SYS3; end
               BYTE_SSEL:  begin sts.is_start = 1'b1; sts.new_mode = MODE_SYS2; end
               BYTE_TUNE:  begin sts.is_start = 1'b1; sts.new_mode = MODE_SYS1; end
               default: ; // real-time, eox and undefined system bytes
            endcase
         end
      end
      sts.cnt_two  = (cnt_ff == CNT_W'(2));
      sts.cnt_last = (cnt_ff == CNT_W'(PARSE_DEPTH - 1));
      sts.rd_last  = ((rd_idx_ff + CNT_W'(1)) == cnt_ff);
      sts.out_free = !valid_ff || rsp_ready;
   end

   always_comb begin
      rs_in  = rs_ff;
      cnt_in = cnt_ff;
      if (cmd.set_rs) rs_in = req_byte;
      if (cmd.start_msg) cnt_in = CNT_W'(1);
      if (cmd.run_status) cnt_in = CNT_W'(2);
      if (cmd.append) cnt_in = cnt_ff + CNT_W'(1);
      if (cmd.clear) cnt_in = '0;
      valid_in = valid_ff;
      if (cmd.emit_two || cmd.emit_three || cmd.emit_sysex) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_ff    <= BYTE_RS_INIT;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         rs_ff    <= rs_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   // message bytes, read pointer and result payload
   always_ff @(posedge clock) begin
      if (cmd.start_msg) b0_ff <= req_byte;
      if (cmd.run_status) begin
         b0_ff <= rs_ff;
         b1_ff <= req_byte;
      end
      if (cmd.append && cnt_ff == CNT_W'(1)) b1_ff <= req_byte;
      if (cmd.rd_start) begin
         rd_idx_ff <= '0;
      end else if (cmd.emit_sysex) begin
         rd_idx_ff <= rd_idx_ff + CNT_W'(1);
      end
      if (cmd.emit_two) begin
         kind_ff <= KIND_TWO;
         stat_ff <= b0_ff;
         d1_ff   <= req_byte;
         d2_ff   <= 8'h00;
         last_ff <= 1'b1;
      end else if (cmd.emit_three) begin
         kind_ff <= KIND_THREE;
         stat_ff <= b0_ff;
         d1_ff   <= b1_ff;
         d2_ff   <= req_byte;
         last_ff <= 1'b1;
      end else if (cmd.emit_sysex) begin
         kind_ff <= KIND_SYSEX;
         stat_ff <= mem_q_ff;
         d1_ff   <= 8'h00;
         d2_ff   <= 8'h00;
         last_ff <= sts.rd_last;
      end
   end

   // sysex store, one write and one registered read per cycle
   always_comb begin
      wr_en   = cmd.start_msg || cmd.append;
      wr_addr = cmd.start_msg ? '0 : cnt_ff[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= req_byte;
      mem_q_ff <= mem[rd_idx_ff[ADDR_W-1:0]];
   end

   assign rsp_valid    = valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_status   = stat_ff;
   assign rsp_data_one = d1_ff;
   assign rsp_data_two = d2_ff;
   assign rsp_last     = last_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/mbp_ctrl.sv -----
// controller: parse mode tracking and sysex release sequencing
// drives the datapath commands; uses mbp_pkg
`default_nettype none

module mbp_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire mbp_pkg::dp_sts_type sts,
   output mbp_pkg::dp_cmd_type      cmd
);
   import mbp_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RD   = 2'd1;
   localparam logic [1:0] ST_LD   = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [2:0] mode_ff, mode_in;
   logic       acc;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      mode_in   = mode_ff;
      req_ready = (state_ff == ST_IDLE) && sts.out_free;
      acc       = req_valid && req_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (sts.is_data) begin
                  unique case (mode_ff)
                     MODE_READY: begin
                        cmd.run_status = 1'b1;
                        mode_in        = MODE_THREE;
                     end
                     MODE_TWO: begin
                        cmd.emit_two = 1'b1;
                        cmd.clear    = 1'b1;
                        mode_in      = MODE_READY;
                     end
                     MODE_THREE: begin
                        if (sts.cnt_two) begin
                           cmd.emit_three = 1'b1;
                           cmd.clear      = 1'b1;
                           mode_in        = MODE_READY;
                        end else begin
                           cmd.append = 1'b1;
                        end
                     end
                     MODE_EXCL: begin
                        // store full without eox: drop the sysex
                        if (sts.cnt_last) begin
                           cmd.clear = 1'b1;
                           mode_in   = MODE_READY;
                        end else begin
                           cmd.append = 1'b1;
                        end
                     end
                     MODE_TC: begin
                        if (sts.is_mmc) begin
                           cmd.append = 1'b1;
                           mode_in    = MODE_EXCL;
                        end else begin
                           cmd.clear = 1'b1;
                           mode_in   = MODE_READY;
                        end
                     end
                     MODE_SYS3: begin
                        if (sts.cnt_two) begin
                           cmd.clear = 1'b1;
                           mode_in   = MODE_READY;
                        end else begin
                           cmd.append = 1'b1;
                        end
                     end
                     default: begin
                        cmd.clear = 1'b1;
                        mode_in   = MODE_READY;
                     end
                  endcase
               end else if (sts.is_eox && mode_ff == MODE_EXCL) begin
                  cmd.append   = 1'b1;
                  cmd.rd_start = 1'b1;
                  mode_in      = MODE_READY;
                  state_in     = ST_RD;
               end else if (sts.is_start) begin
                  cmd.start_msg = 1'b1;
                  cmd.set_rs    = (sts.new_mode == MODE_THREE);
                  mode_in       = (sts.new_mode == MODE_SYS1) ? MODE_READY : sts.new_mode;
               end
            end
         end
         ST_RD: state_in = ST_LD;
         ST_LD: begin
            if (sts.out_free) begin
               cmd.emit_sysex = 1'b1;
               if (sts.rd_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_READY;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/midi_byte_stream_parser.sv -----
// channel  | dir | ports              | contents
// req      | in  | tvalid/tready/tdata | tdata[7:0] midi_byte
// rsp      | out | tvalid/tready/tdata | tdata status_or_sysex_byte, data_one, data_two
//          |     | tuser/tlast         | tuser msg_kind, tlast last_of_run
//
// outside a sysex release, a byte is taken whenever the result register is empty
// or being drained in the same cycle.
// an eox releases the stored sysex one byte at a time (store read, then result
// load), up to PARSE_DEPTH bytes, with the input held off meanwhile.
// synchronous active-high reset; running status restarts at 0x80, no store clear.
// a stalled result stalls the input until it is taken.
`default_nettype none

module midi_byte_stream_parser #(
   parameter int PARSE_DEPTH = mbp_pkg::PARSE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] midi_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] status_or_sysex_byte, [15:8] data_one,
                                         // [23:16] data_two
   output logic [1:0]       rsp_tuser,   // [1:0] msg_kind
   output logic             rsp_tlast    // last_of_run
);
   import mbp_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic [7:0] rsp_status, rsp_data_one, rsp_data_two;

   mbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mbp_datapath #(.PARSE_DEPTH(PARSE_DEPTH)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_byte     (req_tdata),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_kind     (rsp_tuser),
      .rsp_status   (rsp_status),
      .rsp_data_one (rsp_data_one),
      .rsp_data_two (rsp_data_two),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {rsp_data_two, rsp_data_one, rsp_status};

endmodule

`default_nettype wire

// ----- hw/rtl/mbp_checker.sv -----
// port-level checks for the midi byte stream parser, bound to the top level
// uses mbp_pkg
`default_nettype none

module mbp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   import mbp_pkg::*;

   // a blocked result holds off the input
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while result stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // short messages always close their run
   a_short_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_TWO || rsp_tuser == KIND_THREE)) |-> rsp_tlast)
      else $error("short message without last");

   a_sysex_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_SYSEX) |-> (rsp_tdata[23:8] == 16'h0000))
      else $error("sysex item with data bytes");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind midi_byte_stream_parser mbp_checker u_mbp_checker (.*);

`default_nettype wire
